FILE: hdl/uer_pkg.sv
// shared types, codes and constants of the ultrasonic echo ranger
`default_nettype none

package uer_pkg;

    // field widths
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned DIST_W = 11;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CFG_IDX_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 8'd1;

    // register reset values
    localparam logic [CNT_W-1:0] WAIT_LIMIT_RESET = 16'd30000;
    localparam logic [CNT_W-1:0] MAX_WIDTH_RESET  = 16'd60000;

    // measurement status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOECHO = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO   = 2'd3;

    // trigger pulse shape in ticks
    localparam logic [CNT_W-1:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [CNT_W-1:0] TRIG_HIGH_TICKS = 16'd10;

    // ticks per centimetre, and its reciprocal: floor(x/58) = (x*72316) >> 22
    // holds exactly for every x below 2^22/24
    localparam int unsigned  SUM_W      = CNT_W + 1;
    localparam logic [SUM_W-1:0] CM_DIVISOR = 17'd58;
    localparam logic [SUM_W-1:0] CM_RECIP   = 17'd72316;
    localparam int unsigned  CM_SHIFT   = 22;
    localparam int unsigned  PROD_W     = 2 * SUM_W;

    // one result transaction
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [STAT_W-1:0] status;
        logic [DIST_W-1:0] range_cm;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/uer_cfg.sv
// configuration registers: echo wait limit and maximum echo width
`default_nettype none

module uer_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire [uer_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [uer_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                         o_cfg_ready,
    output logic [uer_pkg::CNT_W-1:0]    o_wait_limit,
    output logic [uer_pkg::CNT_W-1:0]    o_max_width
);
    import uer_pkg::*;

    logic [CNT_W-1:0] r_wait_limit;
    logic [CNT_W-1:0] r_max_width;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_limit <= WAIT_LIMIT_RESET;
            r_max_width  <= MAX_WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WAIT_LIMIT: r_wait_limit <= i_cfg_data;
                CFG_MAX_WIDTH:  r_max_width  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_wait_limit = r_wait_limit;
    assign o_max_width  = r_max_width;

endmodule

`default_nettype wire

FILE: hdl/uer_core.sv
// measurement sequencer: trigger pulse, echo wait, width count, distance
`default_nettype none

module uer_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_step,
    input  wire                       i_action,
    input  wire                       i_echo_level,
    input  wire [uer_pkg::CNT_W-1:0]  i_wait_limit,
    input  wire [uer_pkg::CNT_W-1:0]  i_max_width,
    output uer_pkg::t_result          o_result
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TLOW  = 3'd1;
    localparam logic [2:0] PH_THIGH = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_MEAS  = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_tick, n_tick;
    logic [DIST_W-1:0] r_last, n_last;

    logic [CNT_W-1:0]  tick_inc;
    logic              tick_full;
    logic [SUM_W-1:0]  dist_sum;
    logic [PROD_W-1:0] dist_prod;
    logic [DIST_W-1:0] dist_ok;
    logic              fin;
    logic [STAT_W-1:0] fin_status;
    logic [DIST_W-1:0] fin_dist;
    t_result           res;

    assign tick_inc  = r_tick + 16'd1;
    assign tick_full = (r_tick == {CNT_W{1'b1}});

    // (count + 58) / 58 by reciprocal multiply
    assign dist_sum  = {1'b0, r_tick} + CM_DIVISOR;
    assign dist_prod = dist_sum * CM_RECIP;
    assign dist_ok   = dist_prod[CM_SHIFT +: DIST_W];

    // next state and this tick's result
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_last     = r_last;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_dist   = '0;
        res.trigger_level = 1'b0;
        res.busy_res      = 1'b1;
        res.done_res      = 1'b0;
        res.status        = ST_OK;
        res.range_cm      = r_last;

        unique case (r_phase)
            PH_TLOW: begin
                n_tick = tick_inc;
                if (tick_inc >= TRIG_LOW_TICKS) begin
                    n_phase = PH_THIGH;
                    n_tick  = '0;
                end
            end
            PH_THIGH: begin
                res.trigger_level = 1'b1;
                n_tick = tick_inc;
                if (tick_inc >= TRIG_HIGH_TICKS) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_phase = PH_MEAS;
                    n_tick  = '0;
                end else begin
                    // wait counter saturates
                    n_tick = tick_full ? r_tick : tick_inc;
                    if (n_tick >= i_wait_limit) begin
                        fin        = 1'b1;
                        fin_status = ST_NOECHO;
                    end
                end
            end
            PH_MEAS: begin
                if (i_echo_level) begin
                    n_tick = tick_inc;
                    if (tick_full || (tick_inc > i_max_width)) begin
                        fin        = 1'b1;
                        fin_status = ST_LONG;
                    end
                end else if (r_tick == '0) begin
                    fin        = 1'b1;
                    fin_status = ST_ZERO;
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                    fin_dist   = dist_ok;
                end
            end
            default: begin
                // idle and unused codes
                n_phase = PH_IDLE;
                if (i_action) begin
                    n_phase = PH_TLOW;
                    n_tick  = 16'd1;
                end else begin
                    res.busy_res = 1'b0;
                end
            end
        endcase

        // measurement finished on this tick
        if (fin) begin
            n_last  = fin_dist;
            n_phase = PH_IDLE;
            n_tick  = '0;
            res.trigger_level = 1'b0;
            res.busy_res      = 1'b0;
            res.done_res      = 1'b1;
            res.status        = fin_status;
            res.range_cm      = fin_dist;
        end
    end

    // state advances once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_last  <= n_last;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

FILE: hdl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger
`default_nettype none

// Ultrasonic echo ranger. Each input transaction is one microsecond tick
// carrying the sampled echo level and a start request; each tick yields
// exactly one result transaction with the trigger level, busy and done
// flags, a status code and the distance in centimetres. A tick is taken
// every clock cycle unless o_stall is raised: it lands in an input
// register, the sequencer works on it in one pass and writes the result
// register. Throughput is one tick per cycle while the result channel
// does not stall. The result register lets the input register take one
// more tick while a result waits to be taken. Configuration writes (wait
// limit at index 0, maximum width at index 1) are always ready and
// should be issued while no tick is in flight.
module ultrasonic_echo_ranger (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // tick channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_action,
    input  wire                          i_echo_level,
    // result channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_trigger_level,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic [uer_pkg::STAT_W-1:0]   o_status,
    output logic [uer_pkg::DIST_W-1:0]   o_range_cm,
    // configuration channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [uer_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [uer_pkg::CNT_W-1:0]     i_cfg_data
);
    import uer_pkg::*;

    logic             r_in_valid;
    logic             r_in_action;
    logic             r_in_echo;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;
    logic             accept;
    logic [CNT_W-1:0] wait_limit;
    logic [CNT_W-1:0] max_width;
    t_result          core_res;

    // tick moves to the result register when that is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    uer_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_wait_limit (wait_limit),
        .o_max_width  (max_width)
    );

    uer_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_action     (r_in_action),
        .i_echo_level (r_in_echo),
        .i_wait_limit (wait_limit),
        .i_max_width  (max_width),
        .o_result     (core_res)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_action <= i_action;
            r_in_echo   <= i_echo_level;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_trigger_level = r_out.trigger_level;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_status        = r_out.status;
    assign o_range_cm      = r_out.range_cm;

endmodule

`default_nettype wire

FILE: hdl/uer_checker.sv
// port-level checks for the ultrasonic echo ranger, bound to the top level
`default_nettype none

module uer_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_valid,
    input  wire                          i_stall,
    input  wire                          o_trigger_level,
    input  wire                          o_busy_res,
    input  wire                          o_done_res,
    input  wire [uer_pkg::STAT_W-1:0]    o_status,
    input  wire [uer_pkg::DIST_W-1:0]    o_range_cm
);
    import uer_pkg::*;

    // a finished measurement is no longer busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done and busy together");

    // a failure code only comes with done, and with zero distance
    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_done_res && o_range_cm == '0))
        else $error("failure status without done or with distance");

    // trigger is only driven during a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trigger_level) |-> (o_busy_res && !o_done_res))
        else $error("trigger high outside a measurement");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_range_cm) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire
